// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point_segment_distance: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point_segment_distance: next-cycle check failed");

`endif

// ===== sv/psd_pkg.sv =====
`default_nettype none

package psd_pkg;

  localparam int CoordBits = 16;
  localparam int TFrac     = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int DotBits   = ProdBits + 1;
  localparam int LenBits   = ProdBits;
  localparam int RemBits   = DotBits;
  localparam int TBits     = TFrac + 1;
  localparam int SqBits    = ProdBits;
  localparam int RootBits  = SqBits / 2;
  localparam int DistBits  = RootBits;

  typedef enum logic [1:0] {
    CASE_DEGEN = 2'd0,
    CASE_A     = 2'd1,
    CASE_B     = 2'd2,
    CASE_MID   = 2'd3
  } case_t;

  // side data carried alongside the divider
  typedef struct packed {
    case_t                       kind;
    logic signed [DiffBits-1:0]  ex;
    logic signed [DiffBits-1:0]  ey;
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [DiffBits-1:0]  dx;
    logic signed [DiffBits-1:0]  dy;
  } side_t;

endpackage

`default_nettype wire

// ===== sv/psd_div.sv =====
`default_nettype none

// pipelined restoring divider, one quotient bit per stage
module psd_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic [psd_pkg::RemBits-1:0]       num,
  input  wire logic [psd_pkg::LenBits-1:0]       den,
  input  wire psd_pkg::side_t                    in_side,
  output logic                                   out_valid,
  output logic [psd_pkg::TBits-1:0]              t,
  output psd_pkg::side_t                         out_side
);

  localparam int N = psd_pkg::TBits;

  logic [N-1:0]                     vld;
  logic [psd_pkg::RemBits-1:0]      rem   [N];
  logic [psd_pkg::LenBits-1:0]      den_r [N];
  logic [N-1:0]                     quo   [N];
  psd_pkg::side_t                   sd    [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_stage
    logic [psd_pkg::RemBits-1:0] r_sh;
    logic [N-1:0]                q_in;
    logic [psd_pkg::LenBits-1:0] d_in;
    logic                        v_in;
    psd_pkg::side_t              s_in;
    logic                        ge;

    if (k == 0) begin : g_first
      assign r_sh = num;
      assign q_in = '0;
      assign d_in = den;
      assign v_in = in_valid;
      assign s_in = in_side;
    end else begin : g_rest
      assign r_sh = {rem[k-1][psd_pkg::RemBits-2:0], 1'b0};
      assign q_in = quo[k-1];
      assign d_in = den_r[k-1];
      assign v_in = vld[k-1];
      assign s_in = sd[k-1];
    end

    // trial subtract
    assign ge = r_sh >= psd_pkg::RemBits'(d_in);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem[k]   <= ge ? r_sh - psd_pkg::RemBits'(d_in) : r_sh;
      quo[k]   <= {q_in[N-2:0], ge};
      den_r[k] <= d_in;
      sd[k]    <= s_in;
    end
  end

  assign out_valid = vld[N-1];
  assign t         = quo[N-1];
  assign out_side  = sd[N-1];

endmodule

`default_nettype wire

// ===== sv/psd_isqrt.sv =====
`default_nettype none

// pipelined integer square root, one root bit per stage
module psd_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [psd_pkg::SqBits-1:0]    n,
  input  wire psd_pkg::case_t                in_kind,
  output logic                               out_valid,
  output logic [psd_pkg::RootBits-1:0]       root,
  output psd_pkg::case_t                     out_kind
);

  localparam int N = psd_pkg::RootBits;
  localparam int W = psd_pkg::SqBits;

  logic [N-1:0]     vld;
  logic [W-1:0]     rad  [N];
  logic [W-1:0]     res  [N];
  psd_pkg::case_t   kd   [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] Bit = W'(1) << (2 * (N - 1 - k));
    logic [W-1:0]   n_in;
    logic [W-1:0]   r_in;
    logic           v_in;
    psd_pkg::case_t k_in;
    logic [W-1:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign n_in = n;
      assign r_in = '0;
      assign v_in = in_valid;
      assign k_in = in_kind;
    end else begin : g_rest
      assign n_in = rad[k-1];
      assign r_in = res[k-1];
      assign v_in = vld[k-1];
      assign k_in = kd[k-1];
    end

    assign trial = r_in + Bit;
    assign ge    = n_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rad[k] <= ge ? n_in - trial : n_in;
      res[k] <= ge ? (r_in >> 1) + Bit : r_in >> 1;
      kd[k]  <= k_in;
    end
  end

  assign out_valid = vld[N-1];
  assign root      = res[N-1][N-1:0];
  assign out_kind  = kd[N-1];

endmodule

`default_nettype wire

// ===== sv/point_segment_distance.sv =====
`default_nettype none

// channel   direction  handshake         fields
// request   in         start, busy       point_x, point_y, seg_a_x, seg_a_y, seg_b_x, seg_b_y
// result    out        done (strobe)     distance, nearest_case
//
// one request per cycle, each result in the order of its request
// each request passes through the 17-stage divider for t and the 17-stage root pipeline
// busy stays low; synchronous reset clears only the stage valid bits
// the receiver cannot stall, so nothing in the pipe ever waits

module point_segment_distance (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [psd_pkg::CoordBits-1:0]   point_x,
  input  wire logic signed [psd_pkg::CoordBits-1:0]   point_y,
  input  wire logic signed [psd_pkg::CoordBits-1:0]   seg_a_x,
  input  wire logic signed [psd_pkg::CoordBits-1:0]   seg_a_y,
  input  wire logic signed [psd_pkg::CoordBits-1:0]   seg_b_x,
  input  wire logic signed [psd_pkg::CoordBits-1:0]   seg_b_y,
  output logic                                        done,
  output logic [psd_pkg::DistBits-1:0]                distance,
  output logic [1:0]                                  nearest_case
);

  localparam int DW = psd_pkg::DiffBits;
  localparam int CW = psd_pkg::CoordBits;
  localparam int PW = psd_pkg::ProdBits;
  localparam logic [psd_pkg::TBits-1:0] TOne = psd_pkg::TBits'(1) << psd_pkg::TFrac;

  assign busy = 1'b0;

  // stage 1: differences
  logic                 v1, degen1;
  logic signed [DW-1:0] epx1, epy1, fbx1, fby1, dx1, dy1;
  logic signed [CW-1:0] px1, py1, ax1, ay1;
  logic signed [DW-1:0] dx_c, dy_c;

  assign dx_c = DW'(seg_b_x) - DW'(seg_a_x);
  assign dy_c = DW'(seg_b_y) - DW'(seg_a_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    epx1   <= DW'(point_x) - DW'(seg_a_x);
    epy1   <= DW'(point_y) - DW'(seg_a_y);
    fbx1   <= DW'(point_x) - DW'(seg_b_x);
    fby1   <= DW'(point_y) - DW'(seg_b_y);
    dx1    <= dx_c;
    dy1    <= dy_c;
    degen1 <= (dx_c == '0) && (dy_c == '0);
    px1    <= point_x;
    py1    <= point_y;
    ax1    <= seg_a_x;
    ay1    <= seg_a_y;
  end

  // stage 2: products for dot and squared length
  logic                 v2, degen2;
  logic signed [PW-1:0] pd1, pd2, l1, l2;
  logic signed [DW-1:0] epx2, epy2, fbx2, fby2, dx2, dy2;
  logic signed [CW-1:0] px2, py2, ax2, ay2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    pd1    <= epx1 * dx1;
    pd2    <= epy1 * dy1;
    l1     <= dx1 * dx1;
    l2     <= dy1 * dy1;
    degen2 <= degen1;
    epx2   <= epx1;
    epy2   <= epy1;
    fbx2   <= fbx1;
    fby2   <= fby1;
    dx2    <= dx1;
    dy2    <= dy1;
    px2    <= px1;
    py2    <= py1;
    ax2    <= ax1;
    ay2    <= ay1;
  end

  // stage 3: sums and classification
  logic signed [psd_pkg::DotBits-1:0] dot_c;
  logic [psd_pkg::LenBits-1:0]        len_c;
  psd_pkg::case_t                     kind_c;

  assign dot_c = psd_pkg::DotBits'(pd1) + psd_pkg::DotBits'(pd2);
  assign len_c = psd_pkg::LenBits'(unsigned'(l1)) + psd_pkg::LenBits'(unsigned'(l2));

  always_comb begin
    priority if (degen2) begin
      kind_c = psd_pkg::CASE_DEGEN;
    end else if (dot_c < 0) begin
      kind_c = psd_pkg::CASE_A;
    end else if (dot_c > $signed({1'b0, len_c})) begin
      kind_c = psd_pkg::CASE_B;
    end else begin
      kind_c = psd_pkg::CASE_MID;
    end
  end

  logic                          v3;
  logic [psd_pkg::RemBits-1:0]   num3;
  logic [psd_pkg::LenBits-1:0]   den3;
  psd_pkg::side_t                side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    num3       <= (kind_c == psd_pkg::CASE_MID) ? unsigned'(dot_c) : '0;
    den3       <= len_c;
    side3.kind <= kind_c;
    side3.ex   <= (kind_c == psd_pkg::CASE_B) ? fbx2 : epx2;
    side3.ey   <= (kind_c == psd_pkg::CASE_B) ? fby2 : epy2;
    side3.px   <= px2;
    side3.py   <= py2;
    side3.ax   <= ax2;
    side3.ay   <= ay2;
    side3.dx   <= dx2;
    side3.dy   <= dy2;
  end

  // projection parameter t = dot * 2^16 / len2
  logic                        dv;
  logic [psd_pkg::TBits-1:0]   t;
  psd_pkg::side_t              dside;

  psd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .num       (num3),
    .den       (den3),
    .in_side   (side3),
    .out_valid (dv),
    .t         (t),
    .out_side  (dside)
  );

  // stage 4: scale direction magnitudes by t
  localparam int MW = psd_pkg::TBits + DW;
  logic            v4;
  logic [MW-1:0]   mx4, my4;
  psd_pkg::side_t  side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= dv;
    end
  end

  always_ff @(posedge clk) begin
    mx4   <= MW'(t) * MW'(unsigned'(dside.dx < 0 ? -dside.dx : dside.dx));
    my4   <= MW'(t) * MW'(unsigned'(dside.dy < 0 ? -dside.dy : dside.dy));
    side4 <= dside;
  end

  // stage 5: nearest point and error vector
  logic signed [DW:0]   qx, qy, cx, cy, ix, iy;
  logic                 v5;
  logic signed [DW-1:0] ex5, ey5;
  psd_pkg::case_t       kind5;

  assign qx = signed'((DW+1)'(mx4 >> psd_pkg::TFrac));
  assign qy = signed'((DW+1)'(my4 >> psd_pkg::TFrac));
  assign cx = (DW+1)'(side4.ax) + ((side4.dx < 0) ? -qx : qx);
  assign cy = (DW+1)'(side4.ay) + ((side4.dy < 0) ? -qy : qy);
  assign ix = (DW+1)'(side4.px) - cx;
  assign iy = (DW+1)'(side4.py) - cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    ex5   <= (side4.kind == psd_pkg::CASE_MID) ? ix[DW-1:0] : side4.ex;
    ey5   <= (side4.kind == psd_pkg::CASE_MID) ? iy[DW-1:0] : side4.ey;
    kind5 <= side4.kind;
  end

  // stage 6: squares
  logic                 v6;
  logic signed [PW-1:0] sx6, sy6;
  psd_pkg::case_t       kind6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    sx6   <= ex5 * ex5;
    sy6   <= ey5 * ey5;
    kind6 <= kind5;
  end

  // stage 7: squared distance
  logic                         v7;
  logic [psd_pkg::SqBits-1:0]   n7;
  psd_pkg::case_t               kind7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    n7    <= unsigned'(sx6) + unsigned'(sy6);
    kind7 <= kind6;
  end

  // root
  logic                           rv;
  logic [psd_pkg::RootBits-1:0]   root;
  psd_pkg::case_t                 rkind;

  psd_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .n         (n7),
    .in_kind   (kind7),
    .out_valid (rv),
    .root      (root),
    .out_kind  (rkind)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rv;
    end
  end

  always_ff @(posedge clk) begin
    distance     <= root;
    nearest_case <= rkind;
  end

  `include "assert_macros.svh"

  `PSD_ASSERT_IMP(a_degen_len, v3 && side3.kind == psd_pkg::CASE_DEGEN, den3 == '0)
  `PSD_ASSERT_IMP(a_mid_bound, v3 && side3.kind == psd_pkg::CASE_MID, num3 <= psd_pkg::RemBits'(den3))
  `PSD_ASSERT_IMP(a_t_bound, dv && dside.kind == psd_pkg::CASE_MID, t <= TOne)
  `PSD_ASSERT_NEXT(a_div_to_s4, dv, v4)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;

  typedef logic signed [psd_pkg::CoordBits-1:0] coord_t;

  typedef struct {
    coord_t         px, py, ax, ay, bx, by;
    bit             typed;
    int             dval;
    psd_pkg::case_t kind;
  } row_t;

  typedef struct {
    logic [psd_pkg::DistBits-1:0] dval;
    psd_pkg::case_t               kind;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  coord_t point_x = 0, point_y = 0, seg_a_x = 0, seg_a_y = 0, seg_b_x = 0, seg_b_y = 0;
  logic done;
  logic [psd_pkg::DistBits-1:0] distance;
  logic [1:0] nearest_case;

  answer_t        pending_answers[$];
  int             n_requests = 0;
  int             n_errors = 0;
  int             quiet_cycles = 0;
  bit             cur_typed = 0;
  int             cur_dist = 0;
  psd_pkg::case_t cur_kind = psd_pkg::CASE_DEGEN;

  point_segment_distance dut (.*);

  always #10 clk = ~clk;

  // nearest point on a closed segment, distance as floor of the root
  function automatic answer_t segment_distance(coord_t px, coord_t py, coord_t ax,
                                               coord_t ay, coord_t bx, coord_t by);
    longint dx, dy, ex, ey, dot, len2, t, cx, cy, sq, r, mag;
    answer_t res;
    dx = longint'(bx) - longint'(ax);
    dy = longint'(by) - longint'(ay);
    if (dx == 0 && dy == 0) begin
      ex = px - longint'(ax);
      ey = py - longint'(ay);
      res.kind = psd_pkg::CASE_DEGEN;
    end else begin
      dot = (px - longint'(ax)) * dx + (py - longint'(ay)) * dy;
      len2 = dx * dx + dy * dy;
      if (dot < 0) begin
        ex = px - longint'(ax);
        ey = py - longint'(ay);
        res.kind = psd_pkg::CASE_A;
      end else if (dot > len2) begin
        ex = px - longint'(bx);
        ey = py - longint'(by);
        res.kind = psd_pkg::CASE_B;
      end else begin
        t = (dot <<< 16) / len2;
        // per-axis scaling truncated toward zero
        mag = (dx < 0) ? -dx : dx;
        cx = ax + ((dx < 0) ? -((t * mag) >>> 16) : ((t * mag) >>> 16));
        mag = (dy < 0) ? -dy : dy;
        cy = ay + ((dy < 0) ? -((t * mag) >>> 16) : ((t * mag) >>> 16));
        ex = px - cx;
        ey = py - cy;
        res.kind = psd_pkg::CASE_MID;
      end
    end
    sq = ex * ex + ey * ey;
    r = 0;
    for (int i = 17; i >= 0; i--)
      if ((r | (64'sd1 << i)) * (r | (64'sd1 << i)) <= sq) r = r | (64'sd1 << i);
    res.dval = r[psd_pkg::DistBits-1:0];
    return res;
  endfunction

  // request capture, result check and watchdog
  always @(posedge clk) begin
    answer_t want;
    bit      moved;
    moved = 0;
    if (!rst) begin
      if (start && !busy) begin
        if (cur_typed) begin
          want.dval = psd_pkg::DistBits'(cur_dist);
          want.kind = cur_kind;
        end else begin
          want = segment_distance(point_x, point_y, seg_a_x, seg_a_y, seg_b_x, seg_b_y);
        end
        pending_answers.push_back(want);
        n_requests <= n_requests + 1;
        moved = 1;
      end
      if (done) begin
        moved = 1;
        if (pending_answers.size() == 0) begin
          $error("result with no request outstanding");
          n_errors++;
        end else begin
          want = pending_answers.pop_front();
          if (distance !== want.dval) begin
            $error("distance: expected %0d, got %0d", want.dval, distance);
            n_errors++;
          end
          if (nearest_case !== want.kind) begin
            $error("nearest_case: expected %0d, got %0d", want.kind, nearest_case);
            n_errors++;
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // one request, with a random idle gap in front of it
  task automatic send(row_t r, int idle_pct);
    int target;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    point_x <= r.px; point_y <= r.py;
    seg_a_x <= r.ax; seg_a_y <= r.ay;
    seg_b_x <= r.bx; seg_b_y <= r.by;
    cur_typed <= r.typed; cur_dist <= r.dval; cur_kind <= r.kind;
    start <= 1;
    target = n_requests + 1;
    do @(negedge clk); while (n_requests < target);
  endtask

  function automatic coord_t pick(int mode);
    case (mode)
      0: return coord_t'($urandom_range(512) - 256);
      1: return coord_t'($urandom);
      default: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  function automatic row_t random_row();
    row_t r;
    int m, sel;
    sel = $urandom_range(9);
    m = (sel < 5) ? 0 : (sel < 8) ? 1 : 2;
    r.px = pick(m); r.py = pick(m);
    r.ax = pick(m); r.ay = pick(m);
    r.bx = pick(m); r.by = pick(m);
    // degenerate or near-degenerate segments now and then
    if ($urandom_range(19) == 0) begin
      r.bx = r.ax; r.by = r.ay;
    end else if ($urandom_range(19) == 0) begin
      r.bx = r.ax + coord_t'($urandom_range(2) - 1);
      r.by = r.ay + coord_t'($urandom_range(2) - 1);
    end
    r.typed = 0; r.dval = 0; r.kind = psd_pkg::CASE_DEGEN;
    return r;
  endfunction

  row_t directed[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1, 0, psd_pkg::CASE_DEGEN},
    '{16'sd16, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1, 16, psd_pkg::CASE_DEGEN},
    '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
      1, 92680, psd_pkg::CASE_DEGEN},
    '{-16'sd16, 16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 1, 16, psd_pkg::CASE_A},
    '{16'sd48, 16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 1, 32, psd_pkg::CASE_B},
    '{16'sd8, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 1, 16, psd_pkg::CASE_MID},
    // projection landing exactly on the second endpoint
    '{16'sd16, 16'sd5, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 1, 5, psd_pkg::CASE_MID},
    '{16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
      0, 0, psd_pkg::CASE_DEGEN},
    '{-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
      0, 0, psd_pkg::CASE_DEGEN},
    '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32767, -16'sd32768,
      0, 0, psd_pkg::CASE_DEGEN},
    '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32766, 16'sd32767,
      0, 0, psd_pkg::CASE_DEGEN},
    '{16'sd0, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
      0, 0, psd_pkg::CASE_DEGEN},
    '{-16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 0, 0, psd_pkg::CASE_DEGEN},
    '{16'sd5, -16'sd7, -16'sd3, 16'sd2, 16'sd9, -16'sd11, 0, 0, psd_pkg::CASE_DEGEN},
    '{16'sd100, 16'sd33, 16'sd0, 16'sd0, 16'sd3, 16'sd7, 0, 0, psd_pkg::CASE_DEGEN},
    '{16'sd1, 16'sd2, 16'sd0, 16'sd0, 16'sd3, 16'sd7, 0, 0, psd_pkg::CASE_DEGEN}
  };

  initial begin
    int idle_pct[4] = '{0, 64, 0, 6};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (directed[i]) send(directed[i], 0);
    // let the pipe drain before the random part
    start <= 0;
    do @(negedge clk); while (pending_answers.size() != 0);
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 350; k++) begin
        // now and then a request with no idle gap; phases 0 and 2 never idle
        send(random_row(), ($urandom_range(9) == 0) ? 0 : idle_pct[ph]);
      end
    end
    start <= 0;
    do @(negedge clk); while (pending_answers.size() != 0);
    repeat (60) @(negedge clk);
    if (n_errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/psd_pkg.sv
sv/psd_div.sv
sv/psd_isqrt.sv
sv/point_segment_distance.sv
dv/tb.sv
